/* rtl/rbdt_pkg.sv */
// rbdt_pkg: shared types and constants of the reference buffer dependency tracker.
// No dependencies.
`default_nettype none
package rbdt_pkg;
   localparam int IdWidth   = 48;
   localparam int MaskWidth = 8;

   typedef struct packed {
      logic                 is_delta;
      logic [IdWidth-1:0]   pic_id;
      logic [MaskWidth-1:0] referenced_mask;
      logic [MaskWidth-1:0] updated_mask;
   } req_type;

   typedef struct packed {
      logic [IdWidth-1:0] dep_pic_id;
      logic               has_dep;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/rbdt_ram.sv */
// rbdt_ram: generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module rbdt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/rbdt_queue.sv */
// rbdt_queue: two-entry request queue between the front and the back end.
// Depends on rbdt_pkg.
`default_nettype none
module rbdt_queue (
   input  wire               clock,
   input  wire               reset,
   input  wire               in_valid,
   output logic              in_stall,
   input  rbdt_pkg::req_type in_data,
   output logic              out_valid,
   input  wire               out_take,
   output rbdt_pkg::req_type out_data
);
   rbdt_pkg::req_type ent_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_data  = ent_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) ent_ff[wr_ff] <= in_data;
   end
endmodule
`default_nettype wire

/* rtl/rbdt_engine.sv */
// rbdt_engine: back end; walks slots, builds the sorted direct set, prunes it,
// emits results and writes back the slots. Depends on rbdt_pkg and rbdt_ram.
`default_nettype none
module rbdt_engine #(
   parameter int NUM_BUFFERS = 8,
   parameter int ID_BITS     = 48
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               job_valid,
   output logic              job_take,
   input  rbdt_pkg::req_type job,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rbdt_pkg::rsp_type rsp_data
);
   localparam int NB  = NUM_BUFFERS;
   localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
   localparam int CW  = $clog2(NB + 1);
   localparam int AW  = 2 * BW;
   localparam int MW  = rbdt_pkg::MaskWidth;
   localparam int OW  = rbdt_pkg::IdWidth;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_COL   = 3'd1;
   localparam logic [2:0] S_PRUNE = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_WB    = 3'd4;

   logic [2:0]         st_ff, st_in;
   rbdt_pkg::req_type  job_ff;
   logic [ID_BITS-1:0] fid_ff;
   logic [NB-1:0]      rmask, umask;

   logic [NB-1:0]      sv_ff;
   logic [ID_BITS-1:0] sfid_ff [NB];
   logic [CW-1:0]      scnt_ff [NB];

   logic [ID_BITS-1:0] dir_ff [NB];
   logic [NB-1:0]      rem_ff;
   logic [CW-1:0]      nd_ff;

   logic [BW-1:0]      bi_ff;     // slot index
   logic [CW-1:0]      j_ff;      // dep index within slot
   logic               rvld_ff;   // RAM read data valid
   logic               emitted_ff;
   logic [CW-1:0]      k_ff;      // emit index

   logic               ram_we;
   logic [AW-1:0]      ram_wa, ram_ra;
   logic [ID_BITS-1:0] ram_wd, ram_rd;

   // slot index in the upper bits, dep index in the lower bits
   rbdt_ram #(.WIDTH(ID_BITS), .DEPTH(1 << AW)) u_deps (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

   always_comb begin
      for (int i = 0; i < NB; i++) begin
         rmask[i] = (i < MW) ? job_ff.referenced_mask[i % MW] : 1'b0;
         umask[i] = (i < MW) ? job_ff.updated_mask[i % MW] : 1'b0;
      end
   end

   logic slot_rd;
   assign slot_rd = rmask[bi_ff] && sv_ff[bi_ff] && job_ff.is_delta;

   // sorted insert of the current slot's id
   logic [ID_BITS-1:0] cur_id;
   logic               dup;
   logic [NB-1:0]      lt;
   assign cur_id = sfid_ff[bi_ff];
   always_comb begin
      dup = 1'b0;
      for (int k = 0; k < NB; k++) begin
         lt[k] = (k < nd_ff) && (dir_ff[k] < cur_id);
         if ((k < nd_ff) && (dir_ff[k] == cur_id)) dup = 1'b1;
      end
   end

   logic [CW-1:0] cnt_lim;
   assign cnt_lim = scnt_ff[bi_ff];

   logic emit_ok;
   assign emit_ok = (k_ff < nd_ff) && !rem_ff[k_ff[BW-1:0]];
   logic [CW-1:0] k_next;
   logic          more;
   always_comb begin
      more = 1'b0;
      for (int k = 0; k < NB; k++)
         if ((k > k_ff) && (k < nd_ff) && !rem_ff[k]) more = 1'b1;
   end

   logic fire;
   assign fire = rsp_valid && !rsp_stall;
   assign k_next = k_ff + 1'b1;

   always_comb begin
      rsp_valid = (st_ff == S_EMIT) && (emit_ok || (k_ff >= nd_ff && !emitted_ff));
      rsp_data.dep_pic_id = emit_ok ? OW'(dir_ff[k_ff[BW-1:0]]) : '0;
      rsp_data.has_dep    = emit_ok;
      rsp_data.last       = !emit_ok || !more;
      job_take = (st_ff == S_IDLE);
   end

   always_comb begin
      ram_we = (st_ff == S_WB) && umask[bi_ff] && (j_ff < NB);
      ram_wa = AW'({bi_ff, j_ff[BW-1:0]});
      ram_wd = dir_ff[j_ff[BW-1:0]];
      ram_ra = AW'({bi_ff, j_ff[BW-1:0]});
      st_in  = st_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         sv_ff <= '0;
         for (int i = 0; i < NB; i++) scnt_ff[i] <= '0;
      end else begin
         case (st_ff)
            S_IDLE: if (job_valid) begin
               job_ff <= job;
               fid_ff <= ID_BITS'(job.pic_id);
               nd_ff  <= '0;
               rem_ff <= '0;
               bi_ff  <= '0;
               st_ff  <= S_COL;
            end
            S_COL: begin
               if (slot_rd && !dup && nd_ff < NB) begin
                  for (int k = NB - 1; k >= 0; k--) begin
                     if (k < nd_ff + 1) begin
                        if (k > 0 && lt[k-1 < 0 ? 0 : k-1] == 1'b0 && !lt[k] &&
                            (k == 0 || !lt[k-1 < 0 ? 0 : k-1]))
                           dir_ff[k] <= (k > 0 && (k - 1 < nd_ff) &&
                                         !lt[k-1 < 0 ? 0 : k-1]) ? dir_ff[k-1 < 0 ? 0 : k-1] : cur_id;
                        if (k == 0 && !lt[0]) dir_ff[0] <= cur_id;
                        if (k > 0 && lt[k-1 < 0 ? 0 : k-1] && !lt[k]) dir_ff[k] <= cur_id;
                     end
                  end
                  nd_ff <= nd_ff + 1'b1;
               end
               j_ff    <= '0;
               rvld_ff <= 1'b0;
               if (32'(bi_ff) == NB - 1) begin
                  bi_ff <= '0;
                  st_ff <= S_PRUNE;
               end else bi_ff <= bi_ff + 1'b1;
            end
            S_PRUNE: begin
               // RAM read issued at j, data valid next cycle
               rvld_ff <= slot_rd && (j_ff < cnt_lim) && (j_ff < NB);
               if (rvld_ff)
                  for (int k = 0; k < NB; k++)
                     if ((k < nd_ff) && dir_ff[k] == ram_rd) rem_ff[k] <= 1'b1;
               if (slot_rd && j_ff < cnt_lim && j_ff < NB) j_ff <= j_ff + 1'b1;
               else if (!rvld_ff) begin
                  j_ff <= '0;
                  if (32'(bi_ff) == NB - 1) begin
                     bi_ff <= '0;
                     k_ff  <= '0;
                     emitted_ff <= 1'b0;
                     st_ff <= S_EMIT;
                  end else bi_ff <= bi_ff + 1'b1;
               end
            end
            S_EMIT: begin
               if (!emit_ok && k_ff < nd_ff) k_ff <= k_next;
               else if (fire) begin
                  emitted_ff <= 1'b1;
                  if (rsp_data.last) begin
                     j_ff  <= '0;
                     bi_ff <= '0;
                     st_ff <= S_WB;
                  end else k_ff <= k_next;
               end
            end
            S_WB: begin
               if (umask[bi_ff] && j_ff < NB) j_ff <= j_ff + 1'b1;
               else begin
                  if (umask[bi_ff]) begin
                     sv_ff[bi_ff]   <= 1'b1;
                     sfid_ff[bi_ff] <= fid_ff;
                     scnt_ff[bi_ff] <= job_ff.is_delta ? nd_ff : '0;
                  end
                  j_ff <= '0;
                  if (32'(bi_ff) == NB - 1) st_ff <= S_IDLE;
                  else bi_ff <= bi_ff + 1'b1;
               end
            end
            default: st_ff <= st_in;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/reference_buffer_dependency_tracker_top.sv */
// reference_buffer_dependency_tracker_top: top level; request queue and engine.
// Depends on rbdt_pkg, rbdt_queue, rbdt_engine.
//
// Usage: one req transfer per encoded frame (is_delta, pic_id, masks).
// Each frame produces 1..NUM_BUFFERS rsp transfers: ascending frame ids
// with has_dep set, or one empty transfer (has_dep 0); last marks the end.
// A two-entry queue lets req take frames while the engine works; each frame
// is registered in the queue before the engine picks it up. The engine
// handles one frame at a time and takes the next only after the last one is
// written back. Per frame it takes the frame, walks all slots to collect
// ids, walks the read slots to prune the ids found among their stored
// dependencies, emits the remaining ids or the empty result, and walks the
// updated slots to write back the dependency ids, frame id and count.
// Reset clears all slot valid bits and dependency counts at once; no sweep.
// While rsp_stall is high the current result holds and the engine waits.
`default_nettype none
module reference_buffer_dependency_tracker_top #(
   parameter int NUM_BUFFERS = 8,
   parameter int ID_BITS     = 48
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  rbdt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output rbdt_pkg::rsp_type rsp_data
);
   logic              q_valid, q_take;
   rbdt_pkg::req_type q_data;

   rbdt_queue u_queue (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_data(req_data), .out_valid(q_valid), .out_take(q_take), .out_data(q_data)
   );

   rbdt_engine #(.NUM_BUFFERS(NUM_BUFFERS), .ID_BITS(ID_BITS)) u_engine (
      .clock(clock), .reset(reset), .job_valid(q_valid), .job_take(q_take),
      .job(q_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_dep |-> rsp_data.last)
      else $error("empty result without last");
   a_empty_zero_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_dep |-> rsp_data.dep_pic_id == '0)
      else $error("empty result with nonzero id");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
endmodule
`default_nettype wire
